// ===== src/sfd_pkg.sv =====
// Shared types, defaults and codes for the stereo FIR decimator.
package sfd_pkg;

  // Default sizing.
  localparam int TAPS_MAX_DEF     = 512;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEFF_WIDTH_DEF  = 16;
  localparam int ACC_WIDTH_DEF    = 48;

  // Fixed field widths.
  localparam int IO_SAMPLE_W = 16;
  localparam int IO_COEFF_W  = 16;
  localparam int IO_INDEX_W  = 9;
  localparam int IO_RESULT_W = 48;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  // Request types.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEFF  = 1'b1;

  // Register indexes (word address).
  localparam logic [1:0] REG_TAPS  = 2'd0;
  localparam logic [1:0] REG_DECIM = 2'd1;
  localparam logic [1:0] REG_FRAME = 2'd2;

  // Register reset values.
  localparam logic [8:0]  TAPS_RST  = 9'd127;
  localparam logic [2:0]  DECIM_RST = 3'd1;
  localparam logic [15:0] FRAME_RST = 16'd256;

  typedef struct packed {
    logic [8:0]  taps_minus_one;
    logic [2:0]  decimation;
    logic [15:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic clear;  // zero the accumulator
    logic issue;  // a tap read was issued this cycle
  } mac_ctrl_t;

endpackage

// ===== src/sfd_ram.sv =====
// Generic single-port RAM with registered read.
module sfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sfd_regs.sv =====
// APB configuration registers.
module sfd_regs import sfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_TAPS:  cfg_d.taps_minus_one = pwdata[8:0];
        REG_DECIM: cfg_d.decimation     = pwdata[2:0];
        REG_FRAME: cfg_d.frame_length   = pwdata[15:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TAPS:  prdata = APB_DATA_W'(cfg_q.taps_minus_one);
      REG_DECIM: prdata = APB_DATA_W'(cfg_q.decimation);
      REG_FRAME: prdata = APB_DATA_W'(cfg_q.frame_length);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.taps_minus_one <= TAPS_RST;
      cfg_q.decimation     <= DECIM_RST;
      cfg_q.frame_length   <= FRAME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/sfd_mac.sv =====
// Pipelined multiply-accumulate: RAM data, product register, accumulator.
module sfd_mac import sfd_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEFF_WIDTH  = COEFF_WIDTH_DEF,
  parameter int ACC_WIDTH    = ACC_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic [COEFF_WIDTH-1:0]  coeff_i,
  output logic [ACC_WIDTH-1:0]    acc_o,
  output logic                    busy_o
);

  localparam int PROD_W = SAMPLE_WIDTH + COEFF_WIDTH;

  logic                     rd_vld_q;   // RAM data valid
  logic                     prod_vld_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [ACC_WIDTH-1:0]     acc_d, acc_q;

  assign prod_d = $signed(sample_i) * $signed(coeff_i);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + ACC_WIDTH'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= ctrl_i.issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = rd_vld_q || prod_vld_q;

endmodule

// ===== src/stereo_fir_decimator_top.sv =====
// Top level of the interleaved stereo FIR filter with decimation.
//
//  channel  | direction | transfer when             | payload
//  ---------+-----------+----------------------------+-------------------------------------
//  input    | in        | in_valid_i && in_ready_o   | req_type, sample, coeff_index/value
//  result   | out       | out_valid_o && out_ready_i | filtered_value, channel, frame_last
//  config   | in (APB)  | psel&penable&pwrite&pready | taps_minus_one, decimation, frame_len
//
//  Sequence: a sample is accepted, then one tap read per cycle is issued to the
//    delay and coefficient RAMs, then the MAC pipeline drains and the result is
//    handed off; a coefficient write is done as it is accepted.
//  Reset: a clearing pass zeroes both RAMs, sweeping 2*2^clog2(TAPS_MAX) addresses
//    (1024 by default) with in_ready_o low; configuration writes are taken throughout.
//  Stalls: the result register lets the next item in while a result waits; a
//    finished sum waits in the drain step only if that register is still full.
module stereo_fir_decimator_top import sfd_pkg::*; #(
  parameter int TAPS_MAX     = TAPS_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEFF_WIDTH  = COEFF_WIDTH_DEF,
  parameter int ACC_WIDTH    = ACC_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic signed [IO_SAMPLE_W-1:0] sample_i,
  input  logic [IO_INDEX_W-1:0]         coeff_index_i,
  input  logic signed [IO_COEFF_W-1:0]  coeff_value_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [IO_RESULT_W-1:0] filtered_value_o,
  output logic                          channel_o,
  output logic                          frame_last_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready
);

  localparam int PTR_W = $clog2(TAPS_MAX);   // tap / ring pointer
  localparam int DA_W  = PTR_W + 1;          // delay RAM: {channel, pointer}
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAPS_MAX - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_MAC   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  cfg_t      cfg;
  mac_ctrl_t mac_ctrl;
  logic [ACC_WIDTH-1:0] acc;
  logic      mac_busy;

  state_e            state_q, state_d;
  logic [DA_W-1:0]   clr_q, clr_d;
  logic [PTR_W-1:0]  wp_q [2];          // newest sample position per channel
  logic [PTR_W-1:0]  wp_nxt;
  logic              tog_q, tog_d;      // channel of the next sample
  logic [3:0]        phase_q, phase_d;
  logic [15:0]       count_q, count_d;
  // item in flight
  logic              ch_q, ch_d;
  logic              emit_q, emit_d;
  logic              last_q, last_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]  tap_q, tap_d;
  // result register
  logic                   out_valid_q, out_valid_d;
  logic [IO_RESULT_W-1:0] res_val_q;
  logic                   res_ch_q, res_last_q;

  logic              in_xfer, smp_xfer, coef_xfer, out_free, out_load;
  logic [PTR_W-1:0]  tap_last;
  logic [3:0]        phase_inc, phase_mod, phase_nxt;
  logic [16:0]       count_inc, frame_mod;
  logic [15:0]       count_nxt;
  logic signed [63:0] acc_ext;

  // delay and coefficient RAM ports
  logic                    dly_we, coef_we;
  logic [DA_W-1:0]         dly_addr;
  logic [PTR_W-1:0]        coef_addr;
  logic [SAMPLE_WIDTH-1:0] dly_wdata, dly_rdata;
  logic [COEFF_WIDTH-1:0]  coef_wdata, coef_rdata;

  sfd_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  sfd_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (2 ** DA_W)
  ) u_dly_ram (
    .clk_i,
    .we_i    (dly_we),
    .addr_i  (dly_addr),
    .wdata_i (dly_wdata),
    .rdata_o (dly_rdata)
  );

  sfd_ram #(
    .WIDTH (COEFF_WIDTH),
    .DEPTH (2 ** PTR_W)
  ) u_coef_ram (
    .clk_i,
    .we_i    (coef_we),
    .addr_i  (coef_addr),
    .wdata_i (coef_wdata),
    .rdata_o (coef_rdata)
  );

  sfd_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEFF_WIDTH  (COEFF_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_mac (
    .clk_i,
    .rst_ni,
    .ctrl_i   (mac_ctrl),
    .sample_i (dly_rdata),
    .coeff_i  (coef_rdata),
    .acc_o    (acc),
    .busy_o   (mac_busy)
  );

  // Handshakes.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign smp_xfer   = in_xfer && (req_type_i == REQ_SAMPLE);
  assign coef_xfer  = in_xfer && (req_type_i == REQ_COEFF);
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == ST_DRAIN) && !mac_busy && emit_q && out_free;

  // Tap count saturates at the ring size.
  assign tap_last = (32'(cfg.taps_minus_one) >= TAPS_MAX) ? PTR_LAST
                                                          : PTR_W'(cfg.taps_minus_one);

  // Ring pointer advance for the incoming sample's channel.
  assign wp_nxt = (wp_q[tog_q] == PTR_LAST) ? '0 : wp_q[tog_q] + 1'b1;

  // Decimation phase, modulus 2*decimation (zero acts as one).
  assign phase_inc = phase_q + 4'd1;
  assign phase_mod = (cfg.decimation == 3'd0) ? 4'd2 : {cfg.decimation, 1'b0};
  assign phase_nxt = (phase_inc >= phase_mod) ? 4'd0 : phase_inc;

  // Result count, modulus frame_length (zero means 65536).
  assign count_inc = {1'b0, count_q} + 17'd1;
  assign frame_mod = (cfg.frame_length == 16'd0) ? 17'h10000 : {1'b0, cfg.frame_length};
  assign count_nxt = (count_inc >= frame_mod) ? 16'd0 : count_inc[15:0];

  // RAM port muxing: clear sweep, sample/coeff write, tap reads.
  always_comb begin
    dly_we     = 1'b0;
    coef_we    = 1'b0;
    dly_wdata  = '0;
    coef_wdata = '0;
    dly_addr   = {ch_q, rd_ptr_q};
    coef_addr  = tap_q;
    unique case (state_q)
      ST_CLEAR: begin
        dly_we    = 1'b1;
        coef_we   = 1'b1;
        dly_addr  = clr_q;
        coef_addr = clr_q[PTR_W-1:0];
      end
      ST_IDLE: begin
        dly_we     = smp_xfer;
        dly_addr   = {tog_q, wp_nxt};
        dly_wdata  = SAMPLE_WIDTH'(sample_i);
        // indexes past the ring are dropped
        coef_we    = coef_xfer && (32'(coeff_index_i) < TAPS_MAX);
        coef_addr  = PTR_W'(coeff_index_i);
        coef_wdata = COEFF_WIDTH'(coeff_value_i);
      end
      ST_MAC, ST_DRAIN: begin
        dly_addr  = {ch_q, rd_ptr_q};
        coef_addr = tap_q;
      end
      default: begin
        dly_addr  = {ch_q, rd_ptr_q};
        coef_addr = tap_q;
      end
    endcase
  end

  assign mac_ctrl.clear = smp_xfer;
  assign mac_ctrl.issue = (state_q == ST_MAC);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    tog_d       = tog_q;
    phase_d     = phase_q;
    count_d     = count_q;
    ch_d        = ch_q;
    emit_d      = emit_q;
    last_d      = last_q;
    rd_ptr_d    = rd_ptr_q;
    tap_d       = tap_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (smp_xfer) begin
          ch_d     = tog_q;
          tog_d    = ~tog_q;
          phase_d  = phase_nxt;
          emit_d   = (phase_nxt <= 4'd1);
          if (phase_nxt <= 4'd1) begin
            count_d = count_nxt;
          end
          last_d   = (count_nxt == 16'd0);
          rd_ptr_d = wp_nxt;
          tap_d    = '0;
          state_d  = ST_MAC;
        end
      end
      ST_MAC: begin
        // walk back through the ring, newest sample first
        rd_ptr_d = (rd_ptr_q == '0) ? PTR_LAST : rd_ptr_q - 1'b1;
        tap_d    = tap_q + 1'b1;
        if (tap_q == tap_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy && (!emit_q || out_free)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      wp_q[0]     <= '0;
      wp_q[1]     <= '0;
      tog_q       <= 1'b0;
      phase_q     <= '0;
      count_q     <= '0;
      ch_q        <= 1'b0;
      emit_q      <= 1'b0;
      last_q      <= 1'b0;
      rd_ptr_q    <= '0;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      if (smp_xfer) begin
        wp_q[tog_q] <= wp_nxt;
      end
      tog_q       <= tog_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      ch_q        <= ch_d;
      emit_q      <= emit_d;
      last_q      <= last_d;
      rd_ptr_q    <= rd_ptr_d;
      tap_q       <= tap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sign-extend the accumulator onto the 48-bit result.
  assign acc_ext = 64'($signed(acc));

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_val_q  <= acc_ext[IO_RESULT_W-1:0];
      res_ch_q   <= ch_q;
      res_last_q <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = res_val_q;
  assign channel_o        = res_ch_q;
  assign frame_last_o     = res_last_q;

`ifndef SYNTHESIS
  a_load_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DRAIN))
    else $error("result register filled outside the drain step");

  a_sample_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_xfer |=> (state_q == ST_MAC) && (tap_q == '0))
    else $error("accepted sample did not start the tap walk");

  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (tap_q <= tap_last))
    else $error("tap counter ran past the last tap");

  a_ring_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q[0] <= PTR_LAST) && (wp_q[1] <= PTR_LAST) && (rd_ptr_q <= PTR_LAST))
    else $error("ring pointer outside the delay line");

  a_idle_mac_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mac_busy)
    else $error("MAC pipeline busy while taking a new item");
`endif

endmodule
